[sv/b2da_pkg.sv]
package b2da_pkg;

   // Number of decimal places in a 32-bit unsigned value.
   localparam int DIGIT_COUNT = 10;
   localparam int POS_WIDTH = 4;
   localparam int REST_WIDTH = 32;
   // Wide enough to hold nine times the largest place weight.
   localparam int WIDE_WIDTH = 34;

   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(DIGIT_COUNT - 1);

   // Upper two bits of an ASCII decimal character within six bits.
   localparam logic [1:0] ASCII_DIGIT_HIGH = 2'b11;

   typedef logic [3:0] digit_type;
   typedef digit_type [DIGIT_COUNT-1:0] digits_type;
   typedef logic [POS_WIDTH-1:0] pos_type;

   // Place weights, most significant place first.
   localparam logic [WIDE_WIDTH-1:0] PLACE_WEIGHT [DIGIT_COUNT] = '{
      34'd1000000000, 34'd100000000, 34'd10000000, 34'd1000000, 34'd100000,
      34'd10000, 34'd1000, 34'd100, 34'd10, 34'd1
   };

   // What travels down the digit pipeline with each request.
   typedef struct packed {
      logic [REST_WIDTH-1:0] rest;
      digits_type            digits;
      pos_type               first;
      logic                  started;
   } stage_type;

   // Extracts the digit at one place by comparing the remainder against all
   // nine multiples of the place weight, then removes that multiple.
   function automatic stage_type step_digit(stage_type cur, pos_type pos);
      stage_type              nxt;
      logic [WIDE_WIDTH-1:0] wide_rest;
      logic [WIDE_WIDTH-1:0] mult;
      logic [WIDE_WIDTH-1:0] sel;
      digit_type             dig;
      nxt = cur;
      wide_rest = {{(WIDE_WIDTH-REST_WIDTH){1'b0}}, cur.rest};
      sel = '0;
      dig = '0;
      for (int m = 1; m < 10; m++) begin
         mult = WIDE_WIDTH'(PLACE_WEIGHT[pos] * WIDE_WIDTH'(m));
         if (wide_rest >= mult) begin
            sel = mult;
            dig = digit_type'(m);
         end
      end
      nxt.rest = REST_WIDTH'(wide_rest - sel);
      nxt.digits[pos] = dig;
      // The ones place is always printed, so a zero value still gives one digit.
      if (!cur.started && (dig != '0 || pos == LAST_POS)) begin
         nxt.started = 1'b1;
         nxt.first = pos;
      end
      return nxt;
   endfunction

endpackage

[sv/binary_to_decimal_ascii.sv]
// Channel   Handshake              Payload
// request   start / busy           req_value[31:0]
// response  rsp_strobe (no stall)  rsp_digit_char[5:0], rsp_last
//
// Ten pipeline stages each extract one decimal digit, then an output register
// sends the digits one per cycle, leading zeros dropped. The first character
// leaves from the output register once the request has passed every stage; a
// request holds the output while its digits print, setting the sustained rate.
// Reset clears the valid bits only. Busy rises when the output is still sending
// and the pipeline behind it is full; the receiver never stalls.
module binary_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_digit_char,
   output logic        rsp_last
);

   localparam int N = b2da_pkg::DIGIT_COUNT;

   b2da_pkg::stage_type  stage_ff [N];
   b2da_pkg::stage_type  stage_in [N];
   logic [N-1:0]         valid_ff;
   logic [N:0]           ready;

   logic                 out_valid_ff;
   b2da_pkg::digits_type out_digits_ff;
   b2da_pkg::pos_type    out_idx_ff;

   // The output register frees up on the last digit of its request.
   assign ready[N] = !out_valid_ff || (out_idx_ff == b2da_pkg::LAST_POS);
   assign busy = !ready[0];

   // Each place is one register stage with its own valid bit.
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic in_valid;

      assign ready[s] = !valid_ff[s] || ready[s+1];

      if (s == 0) begin : g_first
         b2da_pkg::stage_type seed;
         always_comb begin
            seed.rest = req_value;
            seed.digits = '0;
            seed.first = '0;
            seed.started = 1'b0;
            stage_in[s] = b2da_pkg::step_digit(seed, b2da_pkg::pos_type'(s));
         end
         assign in_valid = start;
      end else begin : g_next
         assign stage_in[s] = b2da_pkg::step_digit(stage_ff[s-1],
                                                   b2da_pkg::pos_type'(s));
         assign in_valid = valid_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= in_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   // Output valid follows the last stage whenever the register is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ready[N]) begin
         out_valid_ff <= valid_ff[N-1];
      end
   end

   // Load a fresh set of digits, or step to the next printed place.
   always_ff @(posedge clock) begin
      if (ready[N]) begin
         out_digits_ff <= stage_ff[N-1].digits;
         out_idx_ff <= stage_ff[N-1].first;
      end else begin
         out_idx_ff <= out_idx_ff + 1'b1;
      end
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_digit_char = {b2da_pkg::ASCII_DIGIT_HIGH, out_digits_ff[out_idx_ff]};
   assign rsp_last = (out_idx_ff == b2da_pkg::LAST_POS);

endmodule
